@@ sv/jfs_pkg.sv @@
// Package for the five-point Jacobi stencil sweep block.
// Holds default sizes, field widths, register codes and the pipeline side-band type.
// No dependencies.
package jfs_pkg;

	localparam int MAX_COLS_DEF   = 4096;
	localparam int VALUE_BITS_DEF = 32;

	localparam int ROW_BITS       = 16;
	localparam int COL_IDX_BITS   = 12;
	localparam int COL_COUNT_BITS = 13;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 4;
	localparam int MIN_COUNT      = 3;

	// result queue depth; the input side counts results still in the relax pipeline against it
	localparam int OUT_FIFO_DEPTH = 8;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW_COUNT = 4'd0,
		REG_COL_COUNT = 4'd1
	} jfs_reg_t;

	// side-band that travels with a cell through the relax pipeline
	typedef struct packed {
		logic                    emit;
		logic                    last;
		logic [ROW_BITS-1:0]     row_idx;
		logic [COL_IDX_BITS-1:0] col_idx;
	} jfs_meta_t;

endpackage

@@ sv/jfs_line_mem.sv @@
// Two line stores: the row above the current one and the row above that.
// Synchronous read with registered outputs; the older store is filled from the data just read.
// Depends on nothing but its parameters.
module jfs_line_mem #(
	parameter int DEPTH     = 4096,
	parameter int ADDR_BITS = 12,
	parameter int VB        = 32
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [VB-1:0]        wr_data,
	output logic [VB-1:0]        prev_rd,
	output logic [VB-1:0]        older_rd
);

	logic [VB-1:0] prev_mem [DEPTH];
	logic [VB-1:0] older_mem [DEPTH];
	logic [VB-1:0] prev_rd_q;
	logic [VB-1:0] older_rd_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			prev_rd_q  <= prev_mem[rd_addr];
			older_rd_q <= older_mem[rd_addr];
		end
		// read-modify-write: the row-above value moves down one line
		if (wr_en) begin
			prev_mem[wr_addr]  <= wr_data;
			older_mem[wr_addr] <= prev_rd_q;
		end
	end

	assign prev_rd  = prev_rd_q;
	assign older_rd = older_rd_q;

endmodule

@@ sv/jfs_relax.sv @@
// Relax pipeline: neighbour window, quarter sum, absolute change and running maximum.
// Takes line store read data in the cycle after the read; pushes results to the output queue.
// Depends on jfs_pkg.
module jfs_relax
	import jfs_pkg::*;
#(
	parameter int VB = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          max_clear,
	input  logic          v_s1,
	input  logic [VB-1:0] cur_s1,
	input  jfs_meta_t     meta_s1,
	input  logic [VB-1:0] prev_rd,
	input  logic [VB-1:0] older_rd,
	output logic          push,
	output logic [VB-1:0] push_new_value,
	output logic [VB-1:0] push_change,
	output logic [VB-1:0] push_max,
	output jfs_meta_t     push_meta,
	output logic [1:0]    busy
);

	// window of the previous two columns
	logic [VB-1:0] pw1_q;
	logic [VB-1:0] pw2_q;
	logic [VB-1:0] up_d_q;
	logic [VB-1:0] down_d_q;

	logic signed [VB+1:0] sum;
	logic signed [VB+1:0] quarter;

	logic          v_s2;
	logic [VB-1:0] nv_s2;
	logic [VB-1:0] ov_s2;
	jfs_meta_t     meta_s2;

	logic signed [VB:0] diff;
	logic signed [VB:0] mag;

	logic          v_s3;
	logic [VB-1:0] nv_s3;
	logic [VB-1:0] change_s3;
	jfs_meta_t     meta_s3;

	logic [VB-1:0] max_q;
	logic [VB-1:0] max_next;

	// result for column k-1 is formed when column k of the row above is read
	always_comb begin
		sum = {{2{up_d_q[VB-1]}}, up_d_q} + {{2{down_d_q[VB-1]}}, down_d_q}
			+ {{2{pw2_q[VB-1]}}, pw2_q} + {{2{prev_rd[VB-1]}}, prev_rd};
		quarter = sum >>> 2;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			pw2_q    <= pw1_q;
			pw1_q    <= prev_rd;
			up_d_q   <= older_rd;
			down_d_q <= cur_s1;
			nv_s2    <= quarter[VB-1:0];
			ov_s2    <= pw1_q;
			meta_s2  <= meta_s1;
		end
	end

	always_comb begin
		diff = {nv_s2[VB-1], nv_s2} - {ov_s2[VB-1], ov_s2};
		mag  = diff[VB] ? -diff : diff;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			nv_s3     <= nv_s2;
			change_s3 <= mag[VB-1:0];
			meta_s3   <= meta_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			max_q <= '0;
		end else begin
			v_s2 <= v_s1 & meta_s1.emit;
			v_s3 <= v_s2;
			if (max_clear) begin
				max_q <= '0;
			end else if (v_s3) begin
				max_q <= meta_s3.last ? '0 : max_next;
			end
		end
	end

	assign max_next = (change_s3 > max_q) ? change_s3 : max_q;

	assign push           = v_s3;
	assign push_new_value = nv_s3;
	assign push_change    = change_s3;
	assign push_max       = max_next;
	assign push_meta      = meta_s3;
	assign busy           = {1'b0, v_s2} + {1'b0, v_s3};

endmodule

@@ sv/jfs_out_fifo.sv @@
// Small result queue in front of the output stream; decouples the pipeline from stalls.
// Depends on nothing but its parameters.
module jfs_out_fifo #(
	parameter int WIDTH    = 125,
	parameter int DEPTH    = 8,
	parameter int CNT_BITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    push_data,
	input  logic                pop_ready,
	output logic                out_valid,
	output logic [WIDTH-1:0]    out_data,
	output logic [CNT_BITS-1:0] count
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid & pop_ready;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/jacobi_five_point_stencil_sweep_top.sv @@
// Five-point Jacobi relaxation over a grid streamed in raster order.
// Cells enter on the s_axis stream, one per request; relaxed interior cells leave on m_axis.
// Row and column counts are written on the cfg channel; a write to either count restarts
// the sweep, writes to any other index are ignored.
// Each accepted cell (r,c) with r >= 2 and 2 <= c reads the two line stores at column c and
// yields the result for interior cell (r-1,c-1); all other cells yield nothing.
// Throughput: one cell per clock while s_axis_tready is high; the line stores have one read
// and one write port each, and every cell does exactly one read and one write at its own
// column. A result is pushed into the output queue from the s3 register and shows on
// m_axis once it reaches the head of the queue.
// The last interior result of a sweep carries tlast; the running maximum clears after it.
// When m_axis stalls, results collect in an eight-entry queue and s_axis_tready drops once
// the queue plus the results still in the pipeline would fill it.
// Reset clears the position counters, running maximum and queue, and sets both counts to 3.
// Line stores are not cleared; rows 0 and 1 fill every entry before any result reads one.
// Configuration is taken every cycle (cfg_ready is always high) and is meant for idle time.
// Depends on jfs_pkg, jfs_line_mem, jfs_relax and jfs_out_fifo.
module jacobi_five_point_stencil_sweep_top
	import jfs_pkg::*;
#(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int IN_TDATA   = ((VALUE_BITS + 7) / 8) * 8,
	parameter int OUT_BITS   = 3 * VALUE_BITS + ROW_BITS + COL_IDX_BITS,
	parameter int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// cell_value
	input  logic [IN_TDATA-1:0]       s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// new_value, row_index, col_index, cell_change, sweep_max_change
	output logic [OUT_TDATA-1:0]      m_axis_tdata,
	output logic                      m_axis_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_BITS  = $clog2(OUT_FIFO_DEPTH + 1);
	localparam int OCC_BITS  = CNT_BITS + 1;
	localparam int FIFO_BITS = OUT_BITS + 1;

	logic [ROW_BITS-1:0] rows_m1_q;
	logic [COL_BITS-1:0] cols_m1_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;

	logic [ROW_BITS-1:0] row_eff;
	logic [ROW_BITS-1:0] rows_m1_d;
	logic [31:0]         col_req;
	logic [31:0]         col_eff;
	logic [COL_BITS-1:0] cols_m1_d;
	logic                cfg_wr;
	logic                cfg_restart;

	logic                in_acc;
	logic                hazard;
	logic [VALUE_BITS-1:0] cur;
	logic [COL_BITS-1:0] col_m1;
	logic [COL_BITS+COL_IDX_BITS-1:0] col_m1_wide;
	jfs_meta_t           meta_in;

	logic                  v_s1;
	logic [COL_BITS-1:0]   addr_s1;
	logic [VALUE_BITS-1:0] cur_s1;
	jfs_meta_t             meta_s1;

	logic [VALUE_BITS-1:0] prev_rd;
	logic [VALUE_BITS-1:0] older_rd;

	logic                  push;
	logic [VALUE_BITS-1:0] push_new_value;
	logic [VALUE_BITS-1:0] push_change;
	logic [VALUE_BITS-1:0] push_max;
	jfs_meta_t             push_meta;
	logic [1:0]            busy;

	logic [FIFO_BITS-1:0]  push_data;
	logic [FIFO_BITS-1:0]  fifo_out;
	logic [CNT_BITS-1:0]   fifo_count;
	logic [OCC_BITS-1:0]   occ;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	// only the two count registers restart the sweep
	assign cfg_restart = cfg_wr & ((cfg_index == REG_ROW_COUNT) | (cfg_index == REG_COL_COUNT));

	always_comb begin
		row_eff   = (cfg_data < ROW_BITS'(MIN_COUNT)) ? ROW_BITS'(MIN_COUNT) : cfg_data;
		rows_m1_d = row_eff - 1'b1;
		col_req   = 32'(cfg_data[COL_COUNT_BITS-1:0]);
		if (col_req < 32'(MIN_COUNT)) begin
			col_eff = 32'(MIN_COUNT);
		end else if (col_req > 32'(MAX_COLS)) begin
			col_eff = 32'(MAX_COLS);
		end else begin
			col_eff = col_req;
		end
		cols_m1_d = COL_BITS'(col_eff - 32'd1);
	end

	// ---------------- position and memory addressing ----------------
	assign cur    = s_axis_tdata[VALUE_BITS-1:0];
	assign hazard = v_s1 & (addr_s1 == col_q);
	assign occ    = OCC_BITS'(fifo_count) + OCC_BITS'(busy) + OCC_BITS'(v_s1 & meta_s1.emit);
	assign s_axis_tready = (occ < OCC_BITS'(OUT_FIFO_DEPTH)) & ~hazard;
	assign in_acc = s_axis_tvalid & s_axis_tready;

	assign col_m1      = col_q - 1'b1;
	assign col_m1_wide = {{COL_IDX_BITS{1'b0}}, col_m1};

	always_comb begin
		meta_in.emit    = (row_q > ROW_BITS'(1)) & (col_q > COL_BITS'(1));
		meta_in.last    = (row_q == rows_m1_q) & (col_q == cols_m1_q);
		meta_in.row_idx = row_q - 1'b1;
		meta_in.col_idx = col_m1_wide[COL_IDX_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m1_q <= ROW_BITS'(MIN_COUNT - 1);
			cols_m1_q <= COL_BITS'(MIN_COUNT - 1);
			row_q     <= '0;
			col_q     <= '0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			if (cfg_wr) begin
				case (cfg_index)
					REG_ROW_COUNT: rows_m1_q <= rows_m1_d;
					REG_COL_COUNT: cols_m1_q <= cols_m1_d;
					default:       rows_m1_q <= rows_m1_q;
				endcase
			end
			if (cfg_restart) begin
				row_q <= '0;
				col_q <= '0;
			end else if (in_acc) begin
				if (col_q == cols_m1_q) begin
					col_q <= '0;
					row_q <= (row_q == rows_m1_q) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1 <= col_q;
			cur_s1  <= cur;
			meta_s1 <= meta_in;
		end
	end

	jfs_line_mem #(
		.DEPTH     (MAX_COLS),
		.ADDR_BITS (COL_BITS),
		.VB        (VALUE_BITS)
	) u_line_mem (
		.clk      (clk),
		.rd_en    (in_acc),
		.rd_addr  (col_q),
		.wr_en    (v_s1),
		.wr_addr  (addr_s1),
		.wr_data  (cur_s1),
		.prev_rd  (prev_rd),
		.older_rd (older_rd)
	);

	jfs_relax #(
		.VB (VALUE_BITS)
	) u_relax (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_clear      (cfg_restart),
		.v_s1           (v_s1),
		.cur_s1         (cur_s1),
		.meta_s1        (meta_s1),
		.prev_rd        (prev_rd),
		.older_rd       (older_rd),
		.push           (push),
		.push_new_value (push_new_value),
		.push_change    (push_change),
		.push_max       (push_max),
		.push_meta      (push_meta),
		.busy           (busy)
	);

	assign push_data = {push_meta.last, push_max, push_change, push_meta.col_idx,
		push_meta.row_idx, push_new_value};

	jfs_out_fifo #(
		.WIDTH    (FIFO_BITS),
		.DEPTH    (OUT_FIFO_DEPTH),
		.CNT_BITS (CNT_BITS)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (fifo_out),
		.count     (fifo_count)
	);

	assign m_axis_tdata = OUT_TDATA'(fifo_out[OUT_BITS-1:0]);
	assign m_axis_tlast = fifo_out[OUT_BITS];

	// ---------------- assertions ----------------
	// queue plus pipeline never promise more than the queue can hold
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= OCC_BITS'(OUT_FIFO_DEPTH))
		else $error("result budget exceeds queue depth");

	// a count register write restarts the raster position
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_restart |=> (row_q == '0) && (col_q == '0))
		else $error("position not cleared by register write");

	// the line store never writes and reads the same column in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && in_acc) |-> (addr_s1 != col_q))
		else $error("line store read collides with pending write");

endmodule
